// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: antecedent and consequent on the same edge.
`define PBS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following edge.
`define PBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pbs_pkg.sv -----
package pbs_pkg;

    localparam int DEF_NUM_PRESETS = 4;
    localparam int DEF_NUM_BANKS   = 4;

    localparam int COUNT_W = 8;
    localparam int CFG_W   = 4;
    localparam int TALLY_W = 4;

    localparam logic [CFG_W-1:0]   STEPS_RESET = 4'd2;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = 4'hf;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2,
        PRESS_NOP   = 2'd3
    } t_press;

    // Move request from the encoder tally to the selection state.
    typedef struct packed {
        logic valid;
        logic fwd;
    } t_move;

endpackage

// ----- design/pbs_if.sv -----
interface pbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] encoder_count;
    logic [1:0] press_code;
    logic       extern_button;

    modport source (output valid, output encoder_count, output press_code,
                    output extern_button, input ready);
    modport sink   (input valid, input encoder_count, input press_code,
                    input extern_button, output ready);
endinterface

interface pbs_out_if #(
    parameter int PW = 2,
    parameter int BW = 2
);
    logic          valid;
    logic          ready;
    logic [PW-1:0] cur_preset;
    logic [BW-1:0] cur_bank;
    logic          pending_valid;
    logic [PW-1:0] pending_preset;
    logic [BW-1:0] pending_bank;
    logic          save_strobe;

    modport source (output valid, output cur_preset, output cur_bank,
                    output pending_valid, output pending_preset,
                    output pending_bank, output save_strobe, input ready);
    modport sink   (input valid, input cur_preset, input cur_bank,
                    input pending_valid, input pending_preset,
                    input pending_bank, input save_strobe, output ready);
endinterface

// ----- design/pbs_encoder.sv -----
`include "assert_macros.svh"

module pbs_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pbs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_fire,
    input  logic [pbs_pkg::COUNT_W-1:0] i_count,
    output pbs_pkg::t_move              o_move
);
    import pbs_pkg::*;

    logic [CFG_W-1:0]   r_steps;
    logic [COUNT_W-1:0] r_last, n_last;
    logic [TALLY_W-1:0] r_up, n_up;
    logic [TALLY_W-1:0] r_dn, n_dn;
    logic [CFG_W-1:0]   thr;

    always_comb begin
        n_up   = r_up;
        n_dn   = r_dn;
        n_last = r_last;
        thr    = (r_steps == '0) ? CFG_W'(1) : r_steps;
        // direct compare, counter wrap is not special
        if (i_count != r_last) begin
            if (i_count > r_last) begin
                if (r_up != TALLY_MAX) n_up = r_up + TALLY_W'(1);
            end else begin
                if (r_dn != TALLY_MAX) n_dn = r_dn + TALLY_W'(1);
            end
            n_last = i_count;
        end
        o_move.valid = (n_up >= thr) || (n_dn >= thr);
        o_move.fwd   = n_up > n_dn;
        if (o_move.valid) begin
            n_up = '0;
            n_dn = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_RESET;
            r_last  <= '0;
            r_up    <= '0;
            r_dn    <= '0;
        end else begin
            if (i_cfg_we) r_steps <= i_cfg_wdata;
            if (i_fire) begin
                r_last <= n_last;
                r_up   <= n_up;
                r_dn   <= n_dn;
            end
        end
    end

    `PBS_ASSERT_NEXT(a_tally_clear, i_clk, i_rst_n, i_fire && o_move.valid,
        r_up == '0 && r_dn == '0, "tallies not cleared after a move")
    `PBS_ASSERT_NEXT(a_last_hold, i_clk, i_rst_n, !i_fire && !i_cfg_we,
        $stable(r_last) && $stable(r_up) && $stable(r_dn), "tally state moved without a beat")

endmodule

// ----- design/pbs_select.sv -----
`include "assert_macros.svh"

module pbs_select #(
    parameter int NUM_PRESETS = pbs_pkg::DEF_NUM_PRESETS,
    parameter int NUM_BANKS   = pbs_pkg::DEF_NUM_BANKS,
    localparam int PW = $clog2(NUM_PRESETS),
    localparam int BW = $clog2(NUM_BANKS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [1:0]     i_press,
    input  logic           i_ext,
    input  pbs_pkg::t_move i_move,
    output logic [PW-1:0]  o_cur_preset,
    output logic [BW-1:0]  o_cur_bank,
    output logic           o_pend_valid,
    output logic [PW-1:0]  o_pend_preset,
    output logic [BW-1:0]  o_pend_bank,
    output logic           o_save
);
    import pbs_pkg::*;

    localparam logic [PW-1:0] P_LAST = PW'(NUM_PRESETS - 1);
    localparam logic [BW-1:0] B_LAST = BW'(NUM_BANKS - 1);

    logic [PW-1:0] r_cur_p, n_cur_p, r_pend_p, n_pend_p, r_prev_p, n_prev_p;
    logic [BW-1:0] r_cur_b, n_cur_b, r_pend_b, n_pend_b, r_prev_b, n_prev_b;
    logic          r_pend_flag, n_pend_flag, r_prev_flag, n_prev_flag;
    logic          r_ext_last, n_ext_last;
    t_press        press;

    always_comb begin
        n_cur_p     = r_cur_p;
        n_cur_b     = r_cur_b;
        n_pend_p    = r_pend_p;
        n_pend_b    = r_pend_b;
        n_pend_flag = r_pend_flag;
        n_prev_p    = r_prev_p;
        n_prev_b    = r_prev_b;
        n_prev_flag = r_prev_flag;
        n_ext_last  = r_ext_last;
        o_save      = 1'b0;

        if (i_move.valid) begin
            if (!r_pend_flag) begin
                n_pend_p    = r_cur_p;
                n_pend_b    = r_cur_b;
                n_pend_flag = 1'b1;
            end
            if (i_move.fwd) begin
                if (n_pend_p < P_LAST) begin
                    n_pend_p = n_pend_p + PW'(1);
                end else begin
                    n_pend_p = '0;
                    n_pend_b = (n_pend_b < B_LAST) ? n_pend_b + BW'(1) : '0;
                end
            end else begin
                if (n_pend_p > '0) begin
                    n_pend_p = n_pend_p - PW'(1);
                end else begin
                    n_pend_p = P_LAST;
                    n_pend_b = (n_pend_b > '0) ? n_pend_b - BW'(1) : B_LAST;
                end
            end
        end

        // external button only sampled on beats with no encoder press
        press = t_press'(i_press);
        if (press == PRESS_NONE) begin
            if (!r_ext_last && i_ext) press = PRESS_SHORT;
            n_ext_last = i_ext;
        end

        case (press)
            PRESS_LONG: begin
                if (n_pend_flag) begin
                    n_prev_p    = r_cur_p;
                    n_prev_b    = r_cur_b;
                    n_prev_flag = 1'b1;
                    n_cur_p     = n_pend_p;
                    n_cur_b     = n_pend_b;
                    n_pend_flag = 1'b0;
                end
                o_save = 1'b1;
            end
            PRESS_SHORT: begin
                if (n_pend_flag) begin
                    n_pend_flag = 1'b0;
                end else if (r_prev_flag) begin
                    n_cur_p  = r_prev_p;
                    n_cur_b  = r_prev_b;
                    n_prev_p = r_cur_p;
                    n_prev_b = r_cur_b;
                end
            end
            default: ;
        endcase

        o_cur_preset  = n_cur_p;
        o_cur_bank    = n_cur_b;
        o_pend_valid  = n_pend_flag;
        o_pend_preset = n_pend_flag ? n_pend_p : '0;
        o_pend_bank   = n_pend_flag ? n_pend_b : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_p     <= '0;
            r_cur_b     <= '0;
            r_pend_p    <= '0;
            r_pend_b    <= '0;
            r_pend_flag <= 1'b0;
            r_prev_p    <= '0;
            r_prev_b    <= '0;
            r_prev_flag <= 1'b0;
            r_ext_last  <= 1'b0;
        end else if (i_fire) begin
            r_cur_p     <= n_cur_p;
            r_cur_b     <= n_cur_b;
            r_pend_p    <= n_pend_p;
            r_pend_b    <= n_pend_b;
            r_pend_flag <= n_pend_flag;
            r_prev_p    <= n_prev_p;
            r_prev_b    <= n_prev_b;
            r_prev_flag <= n_prev_flag;
            r_ext_last  <= n_ext_last;
        end
    end

    `PBS_ASSERT_NEXT(a_long_commits, i_clk, i_rst_n,
        i_fire && i_press == PRESS_LONG, !r_pend_flag, "pending pair kept after long press")
    `PBS_ASSERT_NEXT(a_short_cancels, i_clk, i_rst_n,
        i_fire && i_press == PRESS_SHORT, !r_pend_flag, "pending pair kept after short press")

endmodule

// ----- design/preset_bank_selector.sv -----
// Channel   Dir  Payload                                          Handshake
// i_tick    in   encoder_count, press_code, extern_button         valid/ready
// o_sel     out  cur/pending preset and bank, pending_valid, save valid/ready
// i_cfg     in   steps_per_move                                   write enable
//
// One beat per clock sustained while the output is ready; a beat's result
// reaches the outputs through the input register, then the result register.
// All selection state updates in a single pass between the two registers.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the input register; a new beat is still taken while
// the input register is empty or moving on.
`include "assert_macros.svh"

module preset_bank_selector #(
    parameter int NUM_PRESETS = pbs_pkg::DEF_NUM_PRESETS,
    parameter int NUM_BANKS   = pbs_pkg::DEF_NUM_BANKS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pbs_pkg::CFG_W-1:0] i_cfg_wdata,
    pbs_in_if.sink                    i_tick,
    pbs_out_if.source                 o_sel
);
    import pbs_pkg::*;

    localparam int PW = $clog2(NUM_PRESETS);
    localparam int BW = $clog2(NUM_BANKS);

    logic               r_in_valid;
    logic [COUNT_W-1:0] r_in_count;
    logic [1:0]         r_in_press;
    logic               r_in_ext;

    logic               r_out_valid;
    logic [PW-1:0]      r_out_cur_p, r_out_pend_p;
    logic [BW-1:0]      r_out_cur_b, r_out_pend_b;
    logic               r_out_pend_valid, r_out_save;

    logic               advance, fire;
    t_move              move;

    logic [PW-1:0]      res_cur_p, res_pend_p;
    logic [BW-1:0]      res_cur_b, res_pend_b;
    logic               res_pend_valid, res_save;

    assign advance      = !r_out_valid || o_sel.ready;
    assign fire         = r_in_valid && advance;
    assign i_tick.ready = !r_in_valid || advance;

    pbs_encoder u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_count     (r_in_count),
        .o_move      (move)
    );

    pbs_select #(
        .NUM_PRESETS (NUM_PRESETS),
        .NUM_BANKS   (NUM_BANKS)
    ) u_sel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_press       (r_in_press),
        .i_ext         (r_in_ext),
        .i_move        (move),
        .o_cur_preset  (res_cur_p),
        .o_cur_bank    (res_cur_b),
        .o_pend_valid  (res_pend_valid),
        .o_pend_preset (res_pend_p),
        .o_pend_bank   (res_pend_b),
        .o_save        (res_save)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick.valid && i_tick.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (advance) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_count <= i_tick.encoder_count;
            r_in_press <= i_tick.press_code;
            r_in_ext   <= i_tick.extern_button;
        end
        if (fire) begin
            r_out_cur_p      <= res_cur_p;
            r_out_cur_b      <= res_cur_b;
            r_out_pend_valid <= res_pend_valid;
            r_out_pend_p     <= res_pend_p;
            r_out_pend_b     <= res_pend_b;
            r_out_save       <= res_save;
        end
    end

    assign o_sel.valid          = r_out_valid;
    assign o_sel.cur_preset     = r_out_cur_p;
    assign o_sel.cur_bank       = r_out_cur_b;
    assign o_sel.pending_valid  = r_out_pend_valid;
    assign o_sel.pending_preset = r_out_pend_p;
    assign o_sel.pending_bank   = r_out_pend_b;
    assign o_sel.save_strobe    = r_out_save;

    `PBS_ASSERT_SAME(a_full_stall, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_sel.ready, !i_tick.ready,
        "beat taken with both registers full and output stalled")
    `PBS_ASSERT_NEXT(a_fire_result, i_clk, i_rst_n, fire, r_out_valid,
        "processed beat did not reach the result register")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pbs_pkg::*;

    localparam int NUM_PRESETS = DEF_NUM_PRESETS;
    localparam int NUM_BANKS   = DEF_NUM_BANKS;
    localparam int PRESET_W    = $clog2(NUM_PRESETS);
    localparam int BANK_W      = $clog2(NUM_BANKS);
    localparam logic [PRESET_W-1:0] PRESET_LAST = PRESET_W'(NUM_PRESETS - 1);
    localparam logic [BANK_W-1:0]   BANK_LAST   = BANK_W'(NUM_BANKS - 1);
    localparam int STALL_LIMIT = 2000;
    localparam int BURST_LEN   = 90;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_press             press;
        logic               ext;
    } t_tick_item;

    typedef struct packed {
        logic [PRESET_W-1:0] preset;
        logic [BANK_W-1:0]   bank;
    } t_sel_pair;

    typedef struct packed {
        t_sel_pair cur;
        logic      pending_valid;
        t_sel_pair pending;
        logic      save_strobe;
    } t_sel_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_wdata;

    pbs_in_if                               tick_if ();
    pbs_out_if #(.PW(PRESET_W), .BW(BANK_W)) sel_if ();

    preset_bank_selector #(
        .NUM_PRESETS (NUM_PRESETS),
        .NUM_BANKS   (NUM_BANKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (tick_if),
        .o_sel       (sel_if)
    );

    t_tick_item  tick_pending[$];
    t_sel_result sel_expected[$];
    int          mismatches;
    int          cycle_cnt;
    int          stall_cycles;
    logic        gapless;

    // Predicted selection state
    logic [CFG_W-1:0]   move_threshold;
    t_sel_pair          cur_sel, pend_sel, prev_sel;
    logic               pend_flag, prev_flag;
    logic [COUNT_W-1:0] seen_count;
    logic [TALLY_W-1:0] up_tally, down_tally;
    logic               ext_seen;

    // Stimulus walk state
    logic [COUNT_W-1:0] walk_count;
    logic               walk_up;
    logic               walk_ext;

    assign gapless = (cycle_cnt >= 300) && (cycle_cnt < 500);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_sel_result advance_selection(t_tick_item it);
        logic [CFG_W-1:0] thr;
        t_press           press;
        t_sel_pair        swap;
        t_sel_result      res;
        thr   = (move_threshold == '0) ? CFG_W'(1) : move_threshold;
        press = it.press;

        // direct compare, a counter wrap reads as a step the other way
        if (it.count != seen_count) begin
            if (it.count > seen_count) begin
                if (up_tally != TALLY_MAX) up_tally = up_tally + TALLY_W'(1);
            end else if (down_tally != TALLY_MAX) begin
                down_tally = down_tally + TALLY_W'(1);
            end
            seen_count = it.count;
        end

        if (up_tally >= thr || down_tally >= thr) begin
            if (!pend_flag) begin
                pend_sel  = cur_sel;
                pend_flag = 1'b1;
            end
            if (up_tally > down_tally) begin
                if (pend_sel.preset != PRESET_LAST) begin
                    pend_sel.preset = pend_sel.preset + PRESET_W'(1);
                end else begin
                    pend_sel.preset = '0;
                    pend_sel.bank   = (pend_sel.bank == BANK_LAST) ? '0
                                                                   : pend_sel.bank + BANK_W'(1);
                end
            end else begin
                if (pend_sel.preset != '0) begin
                    pend_sel.preset = pend_sel.preset - PRESET_W'(1);
                end else begin
                    pend_sel.preset = PRESET_LAST;
                    pend_sel.bank   = (pend_sel.bank == '0) ? BANK_LAST
                                                            : pend_sel.bank - BANK_W'(1);
                end
            end
            up_tally   = '0;
            down_tally = '0;
        end

        // external button only looked at when the encoder button is idle
        if (press == PRESS_NONE) begin
            if (!ext_seen && it.ext) press = PRESS_SHORT;
            ext_seen = it.ext;
        end

        case (press)
            PRESS_LONG: begin
                if (pend_flag) begin
                    prev_sel  = cur_sel;
                    prev_flag = 1'b1;
                    cur_sel   = pend_sel;
                    pend_flag = 1'b0;
                end
            end
            PRESS_SHORT: begin
                if (pend_flag) begin
                    pend_flag = 1'b0;
                end else if (prev_flag) begin
                    swap     = cur_sel;
                    cur_sel  = prev_sel;
                    prev_sel = swap;
                end
            end
            default: ;
        endcase

        res.cur           = cur_sel;
        res.pending_valid = pend_flag;
        res.pending       = pend_flag ? pend_sel : '0;
        res.save_strobe   = (press == PRESS_LONG);
        return res;
    endfunction

    task automatic check_field(string name, int expd, int got);
        if (expd != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, got);
            mismatches++;
        end
    endtask

    task automatic queue_tick(int count, t_press press, bit ext);
        t_tick_item it;
        it.count = COUNT_W'(count);
        it.press = press;
        it.ext   = ext;
        tick_pending.push_back(it);
    endtask

    // Mostly runs of encoder motion in one direction, with turn-arounds,
    // odd jumps anywhere, sparse presses and a slowly toggling button.
    task automatic queue_random_ticks(int n);
        t_tick_item it;
        int         roll;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                walk_count = COUNT_W'($urandom);
            end else if (roll < 15) begin
                walk_up = ~walk_up;
            end else if (roll < 75) begin
                walk_count = walk_up ? walk_count + COUNT_W'(1) : walk_count - COUNT_W'(1);
            end
            if ($urandom_range(99) < 8) walk_ext = ~walk_ext;
            roll = $urandom_range(99);
            if (roll < 6)       it.press = PRESS_SHORT;
            else if (roll < 12) it.press = PRESS_LONG;
            else if (roll < 15) it.press = PRESS_NOP;
            else                it.press = PRESS_NONE;
            it.count = walk_count;
            it.ext   = walk_ext;
            tick_pending.push_back(it);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_pending.size() != 0 || tick_if.valid || sel_expected.size() != 0);
    endtask

    task automatic write_steps(logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        move_threshold = value;
    endtask

    // Driver: a new beat goes out once the previous one has been taken
    always @(posedge i_clk) begin : tick_driver
        t_tick_item it;
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                it.count = tick_if.encoder_count;
                it.press = t_press'(tick_if.press_code);
                it.ext   = tick_if.extern_button;
                sel_expected.push_back(advance_selection(it));
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (tick_pending.size() != 0 && (gapless || $urandom_range(99) >= 12)) begin
                    it = tick_pending.pop_front();
                    tick_if.encoder_count <= it.count;
                    tick_if.press_code    <= it.press;
                    tick_if.extern_button <= it.ext;
                    tick_if.valid         <= 1'b1;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : sel_monitor
        t_sel_result expd;
        if (!i_rst_n) begin
            sel_if.ready <= 1'b0;
        end else begin
            if (sel_if.valid && sel_if.ready) begin
                if (sel_expected.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual preset %0d bank %0d",
                             $time, sel_if.cur_preset, sel_if.cur_bank);
                    mismatches++;
                end else begin
                    expd = sel_expected.pop_front();
                    check_field("cur_preset", int'(expd.cur.preset), int'(sel_if.cur_preset));
                    check_field("cur_bank", int'(expd.cur.bank), int'(sel_if.cur_bank));
                    check_field("pending_valid", int'(expd.pending_valid),
                                int'(sel_if.pending_valid));
                    check_field("pending_preset", int'(expd.pending.preset),
                                int'(sel_if.pending_preset));
                    check_field("pending_bank", int'(expd.pending.bank),
                                int'(sel_if.pending_bank));
                    check_field("save_strobe", int'(expd.save_strobe),
                                int'(sel_if.save_strobe));
                end
            end
            sel_if.ready <= gapless || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            cycle_cnt    <= 0;
            stall_cycles <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if ((tick_if.valid && tick_if.ready) || (sel_if.valid && sel_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] phase_steps[$];
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        tick_if.valid         = 1'b0;
        tick_if.encoder_count = '0;
        tick_if.press_code    = PRESS_NONE;
        tick_if.extern_button = 1'b0;
        sel_if.ready          = 1'b0;
        mismatches            = 0;
        cycle_cnt             = 0;
        stall_cycles          = 0;

        move_threshold = STEPS_RESET;
        cur_sel        = '0;
        pend_sel       = '0;
        prev_sel       = '0;
        pend_flag      = 1'b0;
        prev_flag      = 1'b0;
        seen_count     = '0;
        up_tally       = '0;
        down_tally     = '0;
        ext_seen       = 1'b0;
        walk_count     = '0;
        walk_up        = 1'b1;
        walk_ext       = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, threshold at its reset value
        queue_tick(0,   PRESS_SHORT, 0);   // nothing pending, nothing previous
        queue_tick(0,   PRESS_LONG,  0);   // strobe only
        queue_tick(0,   PRESS_NOP,   1);   // button not sampled
        queue_tick(0,   PRESS_NONE,  1);   // button edge, still nothing to do
        queue_tick(0,   PRESS_NONE,  0);
        queue_tick(1,   PRESS_NONE,  0);
        queue_tick(2,   PRESS_NONE,  0);   // forward move
        queue_tick(255, PRESS_NONE,  0);
        queue_tick(254, PRESS_NONE,  0);
        queue_tick(253, PRESS_NONE,  0);   // back move
        queue_tick(0,   PRESS_NONE,  0);   // wrap reads as down
        queue_tick(255, PRESS_NONE,  0);
        queue_tick(0,   PRESS_NONE,  0);   // back past preset and bank zero
        queue_tick(0,   PRESS_LONG,  0);   // commit
        queue_tick(0,   PRESS_SHORT, 0);   // swap with previous
        queue_tick(0,   PRESS_NONE,  1);   // button edge swaps back
        queue_tick(0,   PRESS_NONE,  1);   // held, no edge
        queue_tick(1,   PRESS_NONE,  0);
        queue_tick(2,   PRESS_NONE,  1);   // forward wrap, then button cancels
        queue_tick(3,   PRESS_SHORT, 0);
        queue_tick(4,   PRESS_LONG,  0);
        wait_idle();

        // Equal tallies once the threshold drops under them
        write_steps(4'd15);
        @(negedge i_clk);
        queue_tick(10, PRESS_NONE, 0);
        queue_tick(20, PRESS_NONE, 0);
        queue_tick(30, PRESS_NONE, 0);
        queue_tick(25, PRESS_NONE, 0);
        queue_tick(20, PRESS_NONE, 0);
        queue_tick(15, PRESS_NONE, 0);
        wait_idle();
        write_steps(4'd3);
        @(negedge i_clk);
        queue_tick(15, PRESS_NONE, 0);
        queue_tick(15, PRESS_LONG, 0);
        wait_idle();

        walk_count = 8'd15;
        phase_steps = '{4'd0, 4'd1, 4'd15, CFG_W'($urandom_range(2, 14)),
                        CFG_W'($urandom_range(2, 14)), 4'd2};
        foreach (phase_steps[i]) begin
            write_steps(phase_steps[i]);
            @(negedge i_clk);
            queue_random_ticks(BURST_LEN);
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
